>>> hw/rtl/cop_pkg.sv
// Shared constants for the circle octant point generator.
package cop_pkg;

  // Default coordinate width of center, radius and column.
  localparam int unsigned COORD_BITS_DEF = 10;
  // Width of the two's complement point coordinates.
  localparam int unsigned OUT_BITS       = 12;
  // Width of the stroke width field.
  localparam int unsigned WIDTH_BITS     = 8;
  // Points emitted per column.
  localparam int unsigned NUM_POINTS     = 8;
  localparam int unsigned IDX_BITS       = $clog2(NUM_POINTS);

endpackage

>>> hw/rtl/cop_prep.sv
// Front cells: square radius and column, then bound check and radicand.
module cop_prep import cop_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [COORD_BITS-1:0]     center_x_i,
  input  logic [COORD_BITS-1:0]     center_y_i,
  input  logic [COORD_BITS-1:0]     radius_i,
  input  logic [COORD_BITS-1:0]     column_i,
  input  logic [WIDTH_BITS-1:0]     line_width_i,
  output logic                      valid_o,
  output logic [COORD_BITS-1:0]     cx_o,
  output logic [COORD_BITS-1:0]     cy_o,
  output logic [COORD_BITS-1:0]     x_o,
  output logic [WIDTH_BITS-1:0]     w_o,
  output logic [2*COORD_BITS-1:0]   n_o
);

  localparam int unsigned NW = 2 * COORD_BITS;

  logic                  va_q;
  logic [COORD_BITS-1:0] cxa_q, cya_q, xa_q;
  logic [WIDTH_BITS-1:0] wa_q;
  logic [NW-1:0]         rr_q, xx_q;
  logic [NW:0]           xx2;

  logic                  vb_q;
  logic [COORD_BITS-1:0] cxb_q, cyb_q, xb_q;
  logic [WIDTH_BITS-1:0] wb_q;
  logic [NW-1:0]         nb_q;

  assign xx2 = {xx_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      // Drop columns past the octant bound.
      vb_q <= va_q && (xx2 <= {1'b0, rr_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cxa_q <= center_x_i;
      cya_q <= center_y_i;
      xa_q  <= column_i;
      wa_q  <= line_width_i;
      rr_q  <= NW'(radius_i) * NW'(radius_i);
      xx_q  <= NW'(column_i) * NW'(column_i);
      cxb_q <= cxa_q;
      cyb_q <= cya_q;
      xb_q  <= xa_q;
      wb_q  <= wa_q;
      nb_q  <= rr_q - xx_q;
    end
  end

  assign valid_o = vb_q;
  assign cx_o    = cxb_q;
  assign cy_o    = cyb_q;
  assign x_o     = xb_q;
  assign w_o     = wb_q;
  assign n_o     = nb_q;

endmodule

>>> hw/rtl/cop_sqrt_cell.sv
// One root-bit cell of the square root chain.
module cop_sqrt_cell import cop_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned BIT        = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [COORD_BITS-1:0]     cx_i,
  input  logic [COORD_BITS-1:0]     cy_i,
  input  logic [COORD_BITS-1:0]     x_i,
  input  logic [WIDTH_BITS-1:0]     w_i,
  input  logic [2*COORD_BITS-1:0]   n_i,
  input  logic [COORD_BITS-1:0]     s_i,
  input  logic [2*COORD_BITS-1:0]   sq_i,
  output logic                      valid_o,
  output logic [COORD_BITS-1:0]     cx_o,
  output logic [COORD_BITS-1:0]     cy_o,
  output logic [COORD_BITS-1:0]     x_o,
  output logic [WIDTH_BITS-1:0]     w_o,
  output logic [2*COORD_BITS-1:0]   n_o,
  output logic [COORD_BITS-1:0]     s_o,
  output logic [2*COORD_BITS-1:0]   sq_o
);

  localparam int unsigned NW = 2 * COORD_BITS;

  logic [NW:0]           cand;
  logic                  fits;
  logic                  v_q;
  logic [COORD_BITS-1:0] cx_q, cy_q, x_q, s_q;
  logic [WIDTH_BITS-1:0] w_q;
  logic [NW-1:0]         n_q, sq_q;

  // (s + 2^b)^2 = s^2 + s*2^(b+1) + 2^(2b)
  assign cand = {1'b0, sq_i} + ((NW+1)'(s_i) << (BIT + 1)) + ((NW+1)'(1) << (2 * BIT));
  assign fits = (cand <= {1'b0, n_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= cx_i;
      cy_q <= cy_i;
      x_q  <= x_i;
      w_q  <= w_i;
      n_q  <= n_i;
      s_q  <= fits ? (s_i | (COORD_BITS'(1) << BIT)) : s_i;
      sq_q <= fits ? cand[NW-1:0] : sq_i;
    end
  end

  assign valid_o = v_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign x_o     = x_q;
  assign w_o     = w_q;
  assign n_o     = n_q;
  assign s_o     = s_q;
  assign sq_o    = sq_q;

endmodule

>>> hw/rtl/cop_emitter.sv
// Output cell: round the root and step through the eight symmetric points.
module cop_emitter import cop_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [COORD_BITS-1:0]     cx_i,
  input  logic [COORD_BITS-1:0]     cy_i,
  input  logic [COORD_BITS-1:0]     x_i,
  input  logic [WIDTH_BITS-1:0]     w_i,
  input  logic [2*COORD_BITS-1:0]   n_i,
  input  logic [COORD_BITS-1:0]     s_i,
  input  logic [2*COORD_BITS-1:0]   sq_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [OUT_BITS-1:0] point_x_o,
  output logic signed [OUT_BITS-1:0] point_y_o,
  output logic [WIDTH_BITS-1:0]     width_out_o,
  output logic                      last_o
);

  localparam int unsigned NW = 2 * COORD_BITS;

  typedef enum logic [IDX_BITS-1:0] {
    P_YN_X = 3'd0,
    P_XN_Y = 3'd1,
    P_NX_NY = 3'd2,
    P_NY_NX = 3'd3,
    P_NY_X = 3'd4,
    P_NX_Y = 3'd5,
    P_X_Y = 3'd6,
    P_Y_X = 3'd7
  } point_e;

  logic                  busy_q;
  point_e                idx_q;
  logic [OUT_BITS-1:0]   cx_q, cy_q, x_q, y_q;
  logic [WIDTH_BITS-1:0] w_q;
  logic [NW-1:0]         rem;
  logic [COORD_BITS:0]   y_round;
  logic                  is_last;
  logic                  load;

  // Round half up: bump the floor root when the remainder exceeds it.
  assign rem     = n_i - sq_i;
  assign y_round = (rem > NW'(s_i)) ? ({1'b0, s_i} + (COORD_BITS+1)'(1)) : {1'b0, s_i};

  assign is_last = (idx_q == P_Y_X);
  assign take_o  = !busy_q || (out_ready_i && is_last);
  assign load    = valid_i && take_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= P_YN_X;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= P_YN_X;
    end else if (busy_q && out_ready_i) begin
      busy_q <= !is_last;
      idx_q  <= point_e'(idx_q + IDX_BITS'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cx_q <= OUT_BITS'(cx_i);
      cy_q <= OUT_BITS'(cy_i);
      x_q  <= OUT_BITS'(x_i);
      y_q  <= OUT_BITS'(y_round);
      w_q  <= w_i;
    end
  end

  always_comb begin
    case (idx_q)
      P_YN_X: begin
        point_x_o = cx_q + y_q;
        point_y_o = cy_q - x_q;
      end
      P_XN_Y: begin
        point_x_o = cx_q + x_q;
        point_y_o = cy_q - y_q;
      end
      P_NX_NY: begin
        point_x_o = cx_q - x_q;
        point_y_o = cy_q - y_q;
      end
      P_NY_NX: begin
        point_x_o = cx_q - y_q;
        point_y_o = cy_q - x_q;
      end
      P_NY_X: begin
        point_x_o = cx_q - y_q;
        point_y_o = cy_q + x_q;
      end
      P_NX_Y: begin
        point_x_o = cx_q - x_q;
        point_y_o = cy_q + y_q;
      end
      P_X_Y: begin
        point_x_o = cx_q + x_q;
        point_y_o = cy_q + y_q;
      end
      default: begin
        point_x_o = cx_q + y_q;
        point_y_o = cy_q + x_q;
      end
    endcase
  end

  assign out_valid_o = busy_q;
  assign width_out_o = w_q;
  assign last_o      = is_last;

endmodule

>>> hw/rtl/circle_octant_point_generator.sv
// Top level of the circle octant point generator.
//
// Usage: one input word describes one column of a circle (center, radius,
// column offset x and a stroke width). When 2*x*x <= r*r the block finds
// y = round(sqrt(r*r - x*x)), halves rounded up, and sends eight output
// words, the symmetric points of that column, with last set on the eighth.
// A column past the octant bound yields no output words at all.
//
// Structure: two front cells square r and x and form the radicand, then a
// chain of COORD_BITS root cells, one root bit each, then an output cell
// that rounds and steps through the eight points.
// Path: a column's word passes the two front cells and the root chain, and
// its first point shows once the output cell has loaded it.
// Output: the single output channel carries eight points per column, so the
// output cell loads the next column only as the last point is taken; input
// words are taken back to back while the chain has room.
// Stall: when the receiver holds out_ready_i low, hold the current point
// and freeze the whole chain once its tail word waits; in_ready_o drops.
// Reset: clears the valid and busy flags and the point index; data is not reset.
module circle_octant_point_generator import cop_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [COORD_BITS-1:0]      center_x_i,
  input  logic [COORD_BITS-1:0]      center_y_i,
  input  logic [COORD_BITS-1:0]      radius_i,
  input  logic [COORD_BITS-1:0]      column_i,
  input  logic [WIDTH_BITS-1:0]      line_width_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] point_x_o,
  output logic signed [OUT_BITS-1:0] point_y_o,
  output logic [WIDTH_BITS-1:0]      width_out_o,
  output logic                       last_o
);

  localparam int unsigned NW = 2 * COORD_BITS;

  // Per-stage signals of the root chain; entry 0 feeds the first cell.
  logic                  v_c  [COORD_BITS+1];
  logic [COORD_BITS-1:0] cx_c [COORD_BITS+1];
  logic [COORD_BITS-1:0] cy_c [COORD_BITS+1];
  logic [COORD_BITS-1:0] x_c  [COORD_BITS+1];
  logic [WIDTH_BITS-1:0] w_c  [COORD_BITS+1];
  logic [NW-1:0]         n_c  [COORD_BITS+1];
  logic [COORD_BITS-1:0] s_c  [COORD_BITS+1];
  logic [NW-1:0]         sq_c [COORD_BITS+1];

  logic take;
  logic adv;

  // Advance the whole chain unless its tail word waits on the output cell.
  assign adv        = !v_c[COORD_BITS] || take;
  assign in_ready_o = adv;

  cop_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (in_valid_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .column_i     (column_i),
    .line_width_i (line_width_i),
    .valid_o      (v_c[0]),
    .cx_o         (cx_c[0]),
    .cy_o         (cy_c[0]),
    .x_o          (x_c[0]),
    .w_o          (w_c[0]),
    .n_o          (n_c[0])
  );

  // The root search starts from zero.
  assign s_c[0]  = '0;
  assign sq_c[0] = '0;

  for (genvar i = 0; i < COORD_BITS; i++) begin : g_cell
    cop_sqrt_cell #(
      .COORD_BITS (COORD_BITS),
      .BIT        (COORD_BITS - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v_c[i]),
      .cx_i    (cx_c[i]),
      .cy_i    (cy_c[i]),
      .x_i     (x_c[i]),
      .w_i     (w_c[i]),
      .n_i     (n_c[i]),
      .s_i     (s_c[i]),
      .sq_i    (sq_c[i]),
      .valid_o (v_c[i+1]),
      .cx_o    (cx_c[i+1]),
      .cy_o    (cy_c[i+1]),
      .x_o     (x_c[i+1]),
      .w_o     (w_c[i+1]),
      .n_o     (n_c[i+1]),
      .s_o     (s_c[i+1]),
      .sq_o    (sq_c[i+1])
    );
  end

  cop_emitter #(
    .COORD_BITS (COORD_BITS)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v_c[COORD_BITS]),
    .cx_i        (cx_c[COORD_BITS]),
    .cy_i        (cy_c[COORD_BITS]),
    .x_i         (x_c[COORD_BITS]),
    .w_i         (w_c[COORD_BITS]),
    .n_i         (n_c[COORD_BITS]),
    .s_i         (s_c[COORD_BITS]),
    .sq_i        (sq_c[COORD_BITS]),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .width_out_o (width_out_o),
    .last_o      (last_o)
  );

endmodule

>>> tb/cop_tb_pkg.sv
`timescale 1ns / 1ps
// Point predictor and in-order scoreboard for the circle octant point generator tests.
package cop_tb_pkg;
  import cop_pkg::*;

  typedef struct packed {
    logic [OUT_BITS-1:0]   px;
    logic [OUT_BITS-1:0]   py;
    logic [WIDTH_BITS-1:0] w;
    logic                  last;
  } octant_point_t;

  // Floor of the square root, one root bit per step from the top.
  function automatic int unsigned floor_root(input int unsigned n);
    int unsigned s;
    int unsigned t;
    s = 0;
    for (int b = 11; b >= 0; b--) begin
      t = s | (32'd1 << b);
      if (t * t <= n) s = t;
    end
    return s;
  endfunction

  class octant_scoreboard;
    octant_point_t pending[$];
    int unsigned   errors;

    function new();
      errors = 0;
    endfunction

    function void add_point(input int px, input int py, input logic [WIDTH_BITS-1:0] w,
                            input logic last);
      octant_point_t p;
      p.px   = OUT_BITS'(px);
      p.py   = OUT_BITS'(py);
      p.w    = w;
      p.last = last;
      pending.push_back(p);
    endfunction

    // Queue the eight symmetric points of an accepted column, or none past the bound.
    function void note_column(input int unsigned cx, input int unsigned cy,
                              input int unsigned r, input int unsigned x,
                              input logic [WIDTH_BITS-1:0] w);
      int unsigned n;
      int unsigned s;
      int          y;
      int          ix;
      if (2 * x * x > r * r) return;
      n  = r * r - x * x;
      s  = floor_root(n);
      y  = (n - s * s > s) ? int'(s) + 1 : int'(s);
      ix = int'(x);
      add_point(cx + y,  cy - ix, w, 1'b0);
      add_point(cx + ix, cy - y,  w, 1'b0);
      add_point(cx - ix, cy - y,  w, 1'b0);
      add_point(cx - y,  cy - ix, w, 1'b0);
      add_point(cx - y,  cy + ix, w, 1'b0);
      add_point(cx - ix, cy + y,  w, 1'b0);
      add_point(cx + ix, cy + y,  w, 1'b0);
      add_point(cx + y,  cy + ix, w, 1'b1);
    endfunction

    function void check_point(input octant_point_t got);
      octant_point_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d w=%0d last=%0b", $time,
                 $signed(got.px), $signed(got.py), got.w, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.px !== want.px) begin
        $display("%0t: point_x expected %0d, got %0d", $time, $signed(want.px),
                 $signed(got.px));
        errors++;
      end
      if (got.py !== want.py) begin
        $display("%0t: point_y expected %0d, got %0d", $time, $signed(want.py),
                 $signed(got.py));
        errors++;
      end
      if (got.w !== want.w) begin
        $display("%0t: width_out expected %0d, got %0d", $time, want.w, got.w);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb_circle_octant_point_generator.sv
`timescale 1ns / 1ps
// Randomized handshake test of the circle octant point generator against a point predictor.
module tb_circle_octant_point_generator;
  import cop_pkg::*;
  import cop_tb_pkg::*;

  localparam int unsigned CB          = COORD_BITS_DEF;
  localparam int unsigned NUM_RANDOM  = 400;
  // Cycles after the last expected point in which a stray word would still show.
  localparam int unsigned TAIL_CYCLES = 3 * (CB + 3 + NUM_POINTS);
  // Longest receiver hold-off; the watchdog limit sits well above it.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT  = 5000;

  typedef struct {
    logic [CB-1:0]         cx;
    logic [CB-1:0]         cy;
    logic [CB-1:0]         r;
    logic [CB-1:0]         x;
    logic [WIDTH_BITS-1:0] w;
  } column_req_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_ready;
  logic [CB-1:0]              center_x;
  logic [CB-1:0]              center_y;
  logic [CB-1:0]              radius;
  logic [CB-1:0]              column;
  logic [WIDTH_BITS-1:0]      line_width;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [OUT_BITS-1:0] point_x;
  logic signed [OUT_BITS-1:0] point_y;
  logic [WIDTH_BITS-1:0]      width_out;
  logic                       last;

  octant_scoreboard sb;
  logic             draining;
  int unsigned      idle_cycles;

  circle_octant_point_generator #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .radius_i    (radius),
    .column_i    (column),
    .line_width_i(line_width),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .width_out_o (width_out),
    .last_o      (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one column word at the falling edge and hold it until the block takes it.
  // Leave valid high on return so a following word goes out without a bubble.
  task automatic offer_column(input column_req_t c);
    @(negedge clk_i);
    in_valid   <= 1'b1;
    center_x   <= c.cx;
    center_y   <= c.cy;
    radius     <= c.r;
    column     <= c.x;
    line_width <= c.w;
    do @(posedge clk_i); while (!in_ready);
    sb.note_column(c.cx, c.cy, c.r, c.x, c.w);
  endtask

  // Drop valid for a number of cycles; payload holds its last value.
  task automatic pause_input(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  function automatic column_req_t make_column(input int unsigned cx, input int unsigned cy,
                                              input int unsigned r, input int unsigned x,
                                              input int unsigned w);
    column_req_t c;
    c.cx = CB'(cx);
    c.cy = CB'(cy);
    c.r  = CB'(r);
    c.x  = CB'(x);
    c.w  = WIDTH_BITS'(w);
    return c;
  endfunction

  // Most columns lie inside the octant so that they reach the root chain and the
  // point sequencer; the rest are arbitrary offsets, mostly past the bound.
  function automatic column_req_t random_column();
    column_req_t c;
    int unsigned r;
    int unsigned xmax;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    r    = (pick == 0) ? $urandom_range(0, 15) : $urandom_range(0, (1 << CB) - 1);
    xmax = floor_root((r * r) / 2);
    c.cx = CB'($urandom);
    c.cy = CB'($urandom);
    c.r  = CB'(r);
    c.w  = WIDTH_BITS'($urandom);
    if (pick >= 8)
      c.x = CB'($urandom);
    else if ($urandom_range(0, 7) == 0)
      c.x = CB'(xmax);
    else
      c.x = CB'($urandom_range(0, xmax));
    // Pin a center to an edge now and then so the wrap of the point sums shows.
    if ($urandom_range(0, 9) == 0) c.cx = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 9) == 0) c.cy = $urandom_range(0, 1) ? '1 : '0;
    return c;
  endfunction

  // Check every point word the receiver takes.
  always @(posedge clk_i) begin
    octant_point_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.px   = point_x;
      got.py   = point_y;
      got.w    = width_out;
      got.last = last;
      sb.check_point(got);
    end
  end

  // Count cycles without a word moving on either side; end the run if the block hangs.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: segments of full speed, random stalls and a rotating stall mask,
  // with one long hold-off early on while the sender keeps pushing columns.
  initial begin
    int unsigned seg;
    int unsigned seg_len;
    int unsigned mode;
    logic [7:0]  mask;
    out_ready = 1'b0;
    @(posedge rst_ni);
    seg = 0;
    forever begin
      seg_len = $urandom_range(16, 120);
      mode    = $urandom_range(0, 2);
      mask    = 8'($urandom);
      if (seg == 3) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_ready <= draining;
        end
      end else begin
        for (int i = 0; i < seg_len; i++) begin
          @(negedge clk_i);
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= draining || ($urandom_range(0, 2) != 0);
            default: out_ready <= draining || mask[i % 8];
          endcase
        end
      end
      seg++;
    end
  end

  initial begin
    column_req_t directed[$];
    int unsigned burst_left;
    sb          = new();
    draining    = 1'b0;
    in_valid    = 1'b0;
    center_x    = '0;
    center_y    = '0;
    radius      = '0;
    column      = '0;
    line_width  = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero radius at both center extremes: all eight points on the center.
    directed.push_back(make_column(0, 0, 0, 0, 0));
    directed.push_back(make_column(1023, 1023, 0, 0, 255));
    // Full radius on axis: points run below zero and up to twice the coordinate range.
    directed.push_back(make_column(0, 0, 1023, 0, 1));
    directed.push_back(make_column(1023, 1023, 1023, 0, 128));
    // Last column inside the octant, the first past it, and a far one.
    directed.push_back(make_column(512, 512, 1023, 723, 85));
    directed.push_back(make_column(512, 512, 1023, 724, 170));
    directed.push_back(make_column(300, 700, 1023, 1023, 7));
    directed.push_back(make_column(100, 100, 0, 1, 9));
    // Remainder equal to the floor root rounds down; one more rounds up.
    directed.push_back(make_column(40, 50, 6, 4, 33));
    directed.push_back(make_column(40, 50, 5, 2, 66));
    directed.push_back(make_column(0, 1023, 1, 0, 254));
    directed.push_back(make_column(1023, 0, 2, 1, 127));
    directed.push_back(make_column(341, 682, 1023, 512, 170));
    directed.push_back(make_column(682, 341, 724, 511, 85));
    foreach (directed[i]) offer_column(directed[i]);

    burst_left = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
      end
      offer_column(random_column());
      burst_left--;
    end
    pause_input(1);

    // Let every queued point out, then watch a while for strays.
    draining = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cop_pkg.sv
hw/rtl/cop_prep.sv
hw/rtl/cop_sqrt_cell.sv
hw/rtl/cop_emitter.sv
hw/rtl/circle_octant_point_generator.sv
tb/cop_tb_pkg.sv
tb/tb_circle_octant_point_generator.sv
